>>> design/nstg_pkg.sv
package nstg_pkg;

    // stream and configuration widths
    localparam int TONE_W     = 7;
    localparam int DUR_W      = 16;
    localparam int TEMPO_W    = 10;
    localparam int S_TDATA_W  = 40;
    localparam int SAMPLE_W   = 16;
    localparam int M_TDATA_W  = 16;
    localparam int UPQ_W      = 7;
    localparam int AMP_W      = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_UPQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AMP = 1'b1;

    // item kinds carried in tuser
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [UPQ_W-1:0] UPQ_RESET = 7'd16;
    localparam logic [AMP_W-1:0] AMP_RESET = 15'd16374;

    // tone and timing constants
    localparam int SAMPLE_RATE = 11025;
    localparam int SEC_PER_MIN = 60;
    localparam int NOTE_COUNT  = 86;
    localparam int CHZ_W       = 19;
    localparam longint unsigned DEFAULT_CHZ = 44000;
    localparam longint unsigned RATE_DEN    = 100 * SAMPLE_RATE;

    // serial divider: 17-bit dividend, 12-bit divisor
    localparam int DIV_W      = 17;
    localparam int DSR_W      = 12;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int PER_UNIT_W = 14;

    // divide by 60: drop two bits, multiply by ceil(2^19 / 15), keep bits 30:19
    // exact for every dividend below 2^17
    localparam int          BPS_PROD_W = 31;
    localparam int          RECIP_SH   = 19;
    localparam logic [15:0] RECIP_15   = 16'd34953;

    // note state
    localparam int PHASE_W = 32;
    localparam int LEFT_W  = 30;
    localparam int STATE_DEPTH = 1;

    // sine table
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef struct packed {
        logic              active;
        logic [LEFT_W-1:0] left;
        logic [PHASE_W-1:0] step;
        logic [PHASE_W-1:0] phase;
    } note_state_t;

    typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_DEPTH];
    typedef logic [PHASE_W-1:0] step_rom_t [NOTE_COUNT];

    // note frequencies in units of 0.01 Hz, code 0 is silence
    localparam logic [CHZ_W-1:0] NOTE_CHZ [NOTE_COUNT] = '{
        19'd0,
        19'd3270, 19'd3465, 19'd3671, 19'd3889, 19'd4120, 19'd4365,
        19'd4625, 19'd4900, 19'd5191, 19'd5500, 19'd5827, 19'd6174,
        19'd6541, 19'd6930, 19'd7342, 19'd7778, 19'd8241, 19'd8731,
        19'd9250, 19'd9800, 19'd10383, 19'd11000, 19'd11654, 19'd12347,
        19'd13081, 19'd13859, 19'd14683, 19'd15556, 19'd16481, 19'd17461,
        19'd18500, 19'd19600, 19'd20765, 19'd22000, 19'd23308, 19'd24694,
        19'd26163, 19'd27718, 19'd29366, 19'd31113, 19'd32963, 19'd34923,
        19'd36999, 19'd39200, 19'd41530, 19'd44000, 19'd46616, 19'd49388,
        19'd52325, 19'd55437, 19'd58733, 19'd62225, 19'd65926, 19'd69846,
        19'd73999, 19'd78399, 19'd83061, 19'd88000, 19'd93233, 19'd98777,
        19'd104650, 19'd110873, 19'd117466, 19'd124451, 19'd131851, 19'd139691,
        19'd147998, 19'd156798, 19'd166122, 19'd176000, 19'd186466, 19'd197553,
        19'd209300, 19'd221746, 19'd234932, 19'd248902, 19'd263702, 19'd279383,
        19'd295996, 19'd313596, 19'd332244, 19'd352000, 19'd372931, 19'd395107,
        19'd418601
    };

    // rounded phase increment for a frequency in 0.01 Hz
    function automatic logic [PHASE_W-1:0] step_of(longint unsigned chz);
        longint unsigned num;
        num = (chz << 32) + RATE_DEN / 2;
        return PHASE_W'(num / RATE_DEN);
    endfunction

    function automatic step_rom_t build_step_rom();
        step_rom_t rom;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            rom[i] = step_of(longint'(NOTE_CHZ[i]));
        end
        return rom;
    endfunction

    // quarter-wave Taylor sine of a Q0.32 turn, scaled to 32767
    function automatic logic signed [SAMPLE_W-1:0] fixed_sine(logic [31:0] angle);
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] m;
        logic signed [SAMPLE_W-1:0] mag;
        quad = angle[31:30];
        r = {34'd0, angle[29:0]};
        if (quad[0]) begin
            r = Q30_ONE - r;
        end
        x  = (r * PI_HALF_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        m  = (s * 64'd32767 + 64'd536870912) >> 30;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        mag = SAMPLE_W'(m);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            rom[k] = fixed_sine(32'(k) << (32 - SINE_AW));
        end
        return rom;
    endfunction

endpackage

>>> design/note_sine_tone_generator_core.sv
// tick item: state memory read, sine rom read, amplitude multiply, output register; no new
// item is taken until the result is registered; an idle tick ends after the state memory read
// load item: the bit-serial divider for samples per unit (17 steps, after one multiply for beats
// per second) is skipped when tempo times units per quarter is below 60
// reset: units per quarter 16, amplitude 16374, no note playing, no result pending
module note_sine_tone_generator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [nstg_pkg::S_TDATA_W-1:0]       s_tdata,   // tone[6:0], duration[22:7], tempo[32:23], zero[39:33]
    input  logic                                 s_tuser,   // func: 0 load note, 1 sample tick
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [nstg_pkg::M_TDATA_W-1:0]       m_tdata,   // sample[15:0]
    output logic                                 m_tlast,   // last sample of the note
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nstg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nstg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import nstg_pkg::*;

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;   // state memory data available
    localparam logic [2:0] S_ROM  = 3'd2;   // sine rom data available
    localparam logic [2:0] S_MUL  = 3'd3;   // scaled product available
    localparam logic [2:0] S_DIV1 = 3'd4;   // beats per second
    localparam logic [2:0] S_DIV2 = 3'd5;   // samples per unit
    localparam logic [2:0] S_LEN  = 3'd6;   // note length, write back

    localparam sine_rom_t SINE_ROM     = build_sine_rom();
    localparam step_rom_t STEP_ROM     = build_step_rom();
    localparam logic [PHASE_W-1:0] DEFAULT_STEP = step_of(DEFAULT_CHZ);

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // configuration registers
    logic [UPQ_W-1:0] upq_reg;
    logic [AMP_W-1:0] amp_reg;

    // note state memory: one entry, registered read, valid bit stands in for reset
    note_state_t state_mem [STATE_DEPTH];
    note_state_t st_rd_reg;
    logic        st_valid_reg;
    note_state_t cur_st;
    note_state_t st_wdata;
    logic        st_we;

    // captured item
    logic               func_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [TEMPO_W-1:0] tempo_reg;
    logic [PHASE_W-1:0] step_sel_reg;

    // tick datapath
    logic signed [SAMPLE_W-1:0] rom_q_reg;
    logic                       last_pend_reg;
    logic [2*AMP_W-1:0]         prod_reg;
    logic                       neg_reg;
    logic [AMP_W-1:0]           mag;
    logic [2*AMP_W-1:0]         rnd;
    logic [SAMPLE_W-1:0]        scaled;

    // beats per second from tempo times units per quarter
    logic [BPS_PROD_W-1:0] bps_prod;
    logic [DSR_W-1:0]      bps;

    // serial divider
    logic [DIV_W-1:0]     div_q_reg;
    logic [DSR_W-1:0]     div_r_reg;
    logic [DSR_W-1:0]     div_dsr_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DSR_W:0]       div_trial;
    logic                 div_ge;
    logic [DSR_W-1:0]     div_r_next;
    logic [DIV_W-1:0]     div_q_next;
    logic                 div_done;
    logic [PER_UNIT_W-1:0] per_unit_reg;

    // output register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                last_reg;

    logic in_acc;
    logic out_free;
    logic tick_live;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = sample_reg;
    assign m_tlast   = last_reg;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        // restoring division, one quotient bit per cycle
        div_trial  = {div_r_reg, div_q_reg[DIV_W-1]};
        div_ge     = (div_trial >= {1'b0, div_dsr_reg});
        div_r_next = div_ge ? DSR_W'(div_trial - {1'b0, div_dsr_reg}) : div_trial[DSR_W-1:0];
        div_q_next = {div_q_reg[DIV_W-2:0], div_ge};
        div_done   = (div_cnt_reg == '0);

        // divide by 60: quarter the product, then reciprocal multiply for 1/15
        bps_prod = BPS_PROD_W'(div_q_reg[DIV_W-1:2]) * BPS_PROD_W'(RECIP_15);
        bps      = bps_prod[RECIP_SH +: DSR_W];

        // never-written entry reads as idle, all zero
        cur_st    = st_valid_reg ? st_rd_reg : '0;
        tick_live = (func_reg == FUNC_TICK) && cur_st.active;

        mag    = rom_q_reg[SAMPLE_W-1] ? AMP_W'(-rom_q_reg) : AMP_W'(rom_q_reg);
        rnd    = prod_reg + (2*AMP_W)'(16384);
        scaled = {1'b0, rnd[2*AMP_W-1:AMP_W]};

        st_we    = 1'b0;
        st_wdata = cur_st;
        if (state_reg == S_READ && tick_live) begin
            st_we          = 1'b1;
            st_wdata.phase = cur_st.phase + cur_st.step;
            st_wdata.left  = cur_st.left - LEFT_W'(1);
            st_wdata.active = (cur_st.left != LEFT_W'(1));
        end else if (state_reg == S_LEN) begin
            st_we           = 1'b1;
            st_wdata.phase  = '0;
            st_wdata.step   = step_sel_reg;
            st_wdata.left   = LEFT_W'(dur_reg) * LEFT_W'(per_unit_reg);
            st_wdata.active = (st_wdata.left != '0);
        end

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc) state_next = S_READ;
            end
            S_READ:
            begin
                if (func_reg == FUNC_TICK) state_next = cur_st.active ? S_ROM : S_IDLE;
                else state_next = S_DIV1;
            end
            S_ROM:  state_next = S_MUL;
            S_MUL:
            begin
                if (out_free) state_next = S_IDLE;
            end
            S_DIV1:
            begin
                // zero beats per second skips the division
                state_next = (bps == '0) ? S_LEN : S_DIV2;
            end
            S_DIV2:
            begin
                if (div_done) state_next = S_LEN;
            end
            S_LEN:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            upq_reg       <= UPQ_RESET;
            amp_reg       <= AMP_RESET;
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_UPQ: upq_reg <= cfg_data[UPQ_W-1:0];
                    REG_AMP: amp_reg <= cfg_data[AMP_W-1:0];
                    default: ;
                endcase
            end
            if (st_we) st_valid_reg <= 1'b1;
            if (state_reg == S_MUL && out_free) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            if (state_reg == S_READ) begin
                div_cnt_reg <= DIV_CNT_W'(DIV_W - 1);
            end else if (state_reg == S_DIV2) begin
                if (!div_done) div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
                else div_cnt_reg <= DIV_CNT_W'(DIV_W - 1);
            end
        end
    end

    // state memory
    always_ff @(posedge clk)
    begin
        if (st_we) state_mem[0] <= st_wdata;
        if (in_acc) st_rd_reg <= state_mem[0];
    end

    // sine rom, registered read
    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[cur_st.phase[PHASE_W-1 -: SINE_AW]];
    end

    // payload and datapath
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            func_reg     <= s_tuser;
            dur_reg      <= s_tdata[TONE_W +: DUR_W];
            tempo_reg    <= s_tdata[TONE_W+DUR_W +: TEMPO_W];
            step_sel_reg <= (s_tdata[TONE_W-1:0] < TONE_W'(NOTE_COUNT))
                            ? STEP_ROM[s_tdata[TONE_W-1:0]] : DEFAULT_STEP;
        end

        case (state_reg)
            S_READ:
            begin
                last_pend_reg <= (cur_st.left == LEFT_W'(1));
                div_q_reg     <= DIV_W'(tempo_reg) * DIV_W'(upq_reg);
            end
            S_ROM:
            begin
                prod_reg <= amp_reg * mag;
                neg_reg  <= rom_q_reg[SAMPLE_W-1];
            end
            S_MUL:
            begin
                if (out_free) begin
                    sample_reg <= neg_reg ? -scaled : scaled;
                    last_reg   <= last_pend_reg;
                end
            end
            S_DIV1:
            begin
                // next divide the sample rate by beats per second
                div_q_reg    <= DIV_W'(SAMPLE_RATE);
                div_r_reg    <= '0;
                div_dsr_reg  <= bps;
                per_unit_reg <= '0;
            end
            S_DIV2:
            begin
                div_q_reg <= div_q_next;
                div_r_reg <= div_r_next;
                if (div_done) per_unit_reg <= div_q_next[PER_UNIT_W-1:0];
            end
            default: ;
        endcase
    end

endmodule

>>> design/nstg_checker.sv
module nstg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [nstg_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              m_tlast,
    input logic                              cfg_ready
);
    import nstg_pkg::*;

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // one item at a time: no second item right after an accepted one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted in consecutive cycles");

    // a result never rises while an accepted item is at its state memory read or sine rom read
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready, 1) && !$past(s_tvalid && s_tready, 2))
        else $error("result too soon after an accepted item");

    // configuration writes are never stalled while an input item is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind note_sine_tone_generator_core nstg_checker u_nstg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_ready(cfg_ready)
);
